// File: rtl/assert_macros.svh
// shared assertion forms, clocked on clk and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/wmsb_pkg.sv
package wmsb_pkg;

  localparam int SEQ_DEPTH  = 1024;
  localparam int MAX_WINDOW = 256;
  localparam int ADDR_W     = $clog2(SEQ_DEPTH);
  localparam int CNT_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SYM_W      = 8;
  localparam int WLEN_W     = 9;
  localparam int LEN_W      = 11;
  localparam int SCORE_W    = 11;
  localparam int BEST_W     = 10;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_SCORE   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_B_WINDOW_START = 2'd1,
    REG_A_LENGTH       = 2'd2,
    REG_B_LENGTH       = 2'd3
  } reg_idx_t;

  localparam logic [LEN_W-1:0] DEPTH_CAP = LEN_W'(SEQ_DEPTH);

  function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] len);
    cap_len = (len > DEPTH_CAP) ? DEPTH_CAP : len;
  endfunction

endpackage

// File: rtl/window_match_score_best_top.sv
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// request   | start / busy         | in_operation, in_position, in_symbol,
//           |                      | in_a_window_start
// result    | out_valid (1 cycle)  | out_window_score, out_best_score,
//           |                      | out_best_start, out_best_valid,
//           |                      | out_range_error
// config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready (always 1)
//
// Writes, clears and out-of-range windows: result in the cycle after the request,
// busy stays low, one request per cycle.
// A scored window of window_length symbols: busy through the read and finish states,
// one symbol pair read per cycle through the single port of each store; result
// in the first cycle with busy low, when a new request can be taken.
// Reset (rst_n low, synchronous) clears the best and the registers, but sets
// window_length to 1; the stores are not cleared. The result channel cannot stall.
`include "assert_macros.svh"

module window_match_score_best_top import wmsb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_operation,
  input  logic [ADDR_W-1:0]         in_position,
  input  logic [SYM_W-1:0]          in_symbol,
  input  logic [ADDR_W-1:0]         in_a_window_start,
  output logic                      out_valid,
  output logic signed [SCORE_W-1:0] out_window_score,
  output logic [BEST_W-1:0]         out_best_score,
  output logic [ADDR_W-1:0]         out_best_start,
  output logic                      out_best_valid,
  output logic                      out_range_error,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_FINISH} state_t;

  state_t                     state_r;
  logic [WLEN_W-1:0]          window_length_r;
  logic [ADDR_W-1:0]          b_window_start_r;
  logic [LEN_W-1:0]           a_length_r;
  logic [LEN_W-1:0]           b_length_r;
  logic [BEST_W-1:0]          best_score_r;
  logic [ADDR_W-1:0]          best_start_r;
  logic                       best_valid_r;
  logic [ADDR_W-1:0]          a_start_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       pend_r;
  logic signed [SCORE_W-1:0]  score_r;
  logic signed [SCORE_W-1:0]  score_nxt;

  logic                       accept;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;
  op_t                        op;
  logic                       write_err;
  logic                       score_err;
  logic [LEN_W-1:0]           a_end;
  logic [LEN_W-1:0]           b_end;
  logic                       last_issue;
  logic                       better;

  logic                       a_we;
  logic                       b_we;
  logic [ADDR_W-1:0]          a_addr;
  logic [ADDR_W-1:0]          b_addr;
  logic [SYM_W-1:0]           a_rdata;
  logic [SYM_W-1:0]           b_rdata;

  assign pready  = 1'b1;
  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign op      = op_t'(in_operation);

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_LENGTH:  prdata = 32'(window_length_r);
      REG_B_WINDOW_START: prdata = 32'(b_window_start_r);
      REG_A_LENGTH:       prdata = 32'(a_length_r);
      REG_B_LENGTH:       prdata = 32'(b_length_r);
      default:            prdata = '0;
    endcase
  end

  assign a_end = LEN_W'(in_a_window_start) + LEN_W'(window_length_r);
  assign b_end = LEN_W'(b_window_start_r) + LEN_W'(window_length_r);
  assign score_err = (window_length_r == '0) ||
                     (window_length_r > WLEN_W'(MAX_WINDOW)) ||
                     (a_end > cap_len(a_length_r)) ||
                     (b_end > cap_len(b_length_r));
  assign write_err = LEN_W'(in_position) >=
                     cap_len((op == OP_WRITE_A) ? a_length_r : b_length_r);

  assign a_we   = accept && (op == OP_WRITE_A);
  assign b_we   = accept && (op == OP_WRITE_B);
  assign a_addr = (state_r == ST_READ) ? ADDR_W'(a_start_r + ADDR_W'(cnt_r)) : in_position;
  assign b_addr = (state_r == ST_READ) ? ADDR_W'(b_window_start_r + ADDR_W'(cnt_r))
                                       : in_position;

  wmsb_ram #(.WIDTH(SYM_W), .DEPTH(SEQ_DEPTH)) u_seq_a (
    .clk   (clk),
    .we    (a_we),
    .addr  (a_addr),
    .wdata (in_symbol),
    .rdata (a_rdata)
  );

  wmsb_ram #(.WIDTH(SYM_W), .DEPTH(SEQ_DEPTH)) u_seq_b (
    .clk   (clk),
    .we    (b_we),
    .addr  (b_addr),
    .wdata (in_symbol),
    .rdata (b_rdata)
  );

  assign score_nxt  = (a_rdata == b_rdata) ? score_r + SCORE_W'(2) : score_r - SCORE_W'(1);
  assign last_issue = (WLEN_W'(cnt_r) == window_length_r - WLEN_W'(1));
  assign better     = !score_nxt[SCORE_W-1] && (score_nxt != '0) &&
                      (BEST_W'(score_nxt) > best_score_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      window_length_r  <= WLEN_W'(1);
      b_window_start_r <= '0;
      a_length_r       <= '0;
      b_length_r       <= '0;
      best_score_r     <= '0;
      best_start_r     <= '0;
      best_valid_r     <= 1'b0;
      pend_r           <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      pend_r <= (state_r == ST_READ);
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_WINDOW_LENGTH:  window_length_r  <= pwdata[WLEN_W-1:0];
          REG_B_WINDOW_START: b_window_start_r <= pwdata[ADDR_W-1:0];
          REG_A_LENGTH:       a_length_r       <= pwdata[LEN_W-1:0];
          REG_B_LENGTH:       b_length_r       <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_WRITE_A, OP_WRITE_B: begin
                out_valid        <= 1'b1;
                out_window_score <= '0;
                out_range_error  <= write_err;
                out_best_score   <= best_score_r;
                out_best_start   <= best_start_r;
                out_best_valid   <= best_valid_r;
              end
              OP_SCORE: begin
                out_valid        <= score_err;
                out_window_score <= '0;
                out_range_error  <= score_err;
                out_best_score   <= best_score_r;
                out_best_start   <= best_start_r;
                out_best_valid   <= best_valid_r;
                if (!score_err) begin
                  a_start_r <= in_a_window_start;
                  cnt_r     <= '0;
                  score_r   <= '0;
                  state_r   <= ST_READ;
                end
              end
              OP_CLEAR: begin
                out_valid        <= 1'b1;
                out_window_score <= '0;
                out_range_error  <= 1'b0;
                best_score_r     <= '0;
                best_start_r     <= '0;
                best_valid_r     <= 1'b0;
                out_best_score   <= '0;
                out_best_start   <= '0;
                out_best_valid   <= 1'b0;
              end
              default: out_valid <= 1'b0;
            endcase
          end else begin
            out_valid <= 1'b0;
          end
        end
        ST_READ: begin
          out_valid <= 1'b0;
          if (pend_r) begin
            score_r <= score_nxt;
          end
          cnt_r <= cnt_r + CNT_W'(1);
          if (last_issue) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          out_valid        <= 1'b1;
          out_window_score <= score_nxt;
          out_range_error  <= 1'b0;
          if (better) begin
            best_score_r   <= BEST_W'(score_nxt);
            best_start_r   <= a_start_r;
            best_valid_r   <= 1'b1;
            out_best_score <= BEST_W'(score_nxt);
            out_best_start <= a_start_r;
            out_best_valid <= 1'b1;
          end else begin
            out_best_score <= best_score_r;
            out_best_start <= best_start_r;
            out_best_valid <= best_valid_r;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          out_valid <= 1'b0;
          state_r   <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_score_busy, accept && (op == OP_SCORE) && !score_err, busy && !out_valid)
  `ASSERT_IMPL(a_best_valid, 1'b1, best_valid_r == (best_score_r != '0))
  `ASSERT_IMPL(a_err_zero, out_valid && out_range_error, out_window_score == '0)
  `ASSERT_NEXT(a_finish_out, state_r == ST_FINISH, out_valid && !busy)

endmodule

// File: rtl/wmsb_ram.sv
module wmsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wmsb_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] position;
    logic [SYM_W-1:0]  symbol;
    logic [ADDR_W-1:0] a_start;
  } match_req_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] window_score;
    logic [BEST_W-1:0]         best_score;
    logic [ADDR_W-1:0]         best_start;
    logic                      best_valid;
    logic                      range_error;
  } score_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_operation = '0;
  logic [ADDR_W-1:0]         in_position = '0;
  logic [SYM_W-1:0]          in_symbol = '0;
  logic [ADDR_W-1:0]         in_a_window_start = '0;
  logic                      out_valid;
  logic signed [SCORE_W-1:0] out_window_score;
  logic [BEST_W-1:0]         out_best_score;
  logic [ADDR_W-1:0]         out_best_start;
  logic                      out_best_valid;
  logic                      out_range_error;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [3:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  window_match_score_best_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_symbol         (in_symbol),
    .in_a_window_start (in_a_window_start),
    .out_valid         (out_valid),
    .out_window_score  (out_window_score),
    .out_best_score    (out_best_score),
    .out_best_start    (out_best_start),
    .out_best_valid    (out_best_valid),
    .out_range_error   (out_range_error),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copies and scorer state
  int          cur_wlen = 1;
  int          cur_b_start = 0;
  int          cur_a_len = 0;
  int          cur_b_len = 0;
  bit [7:0]    mirror_a [SEQ_DEPTH];
  bit [7:0]    mirror_b [SEQ_DEPTH];
  int          best_score_q = 0;
  int          best_start_q = 0;
  bit          best_valid_q = 1'b0;

  // what the stimulus has queued to be written so far
  bit [7:0]    plan_a [SEQ_DEPTH];
  bit [7:0]    plan_b [SEQ_DEPTH];
  bit          plan_a_set [SEQ_DEPTH];
  bit          plan_b_set [SEQ_DEPTH];

  match_req_t    pending_reqs [$];
  score_result_t expected_scores [$];
  match_req_t    cur_req;
  bit            cur_valid = 1'b0;
  int            idle_pct = 28;
  int            phase_items = 0;
  int            last_start = 0;
  int            mismatch_count = 0;

  function automatic int clamp_depth(int len);
    return (len > SEQ_DEPTH) ? SEQ_DEPTH : len;
  endfunction

  function automatic bit window_loaded(int a_start);
    return cur_wlen != 0 && cur_wlen <= MAX_WINDOW &&
           a_start + cur_wlen <= clamp_depth(cur_a_len) &&
           cur_b_start + cur_wlen <= clamp_depth(cur_b_len);
  endfunction

  function automatic score_result_t predict_score(match_req_t r);
    score_result_t res;
    int            loaded;
    int            acc;
    res = '0;
    acc = 0;
    case (r.op)
      OP_WRITE_A, OP_WRITE_B: begin
        loaded = clamp_depth(r.op == OP_WRITE_A ? cur_a_len : cur_b_len);
        res.range_error = (r.position >= loaded);
        if (r.op == OP_WRITE_A) mirror_a[r.position] = r.symbol;
        else mirror_b[r.position] = r.symbol;
      end
      OP_SCORE: begin
        if (!window_loaded(r.a_start)) begin
          res.range_error = 1'b1;
        end else begin
          for (int k = 0; k < cur_wlen; k++)
            acc += (mirror_a[r.a_start + k] == mirror_b[cur_b_start + k]) ? 2 : -1;
          if (acc > 0 && acc > best_score_q) begin
            best_score_q = acc;
            best_start_q = r.a_start;
            best_valid_q = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        best_score_q = 0;
        best_start_q = 0;
        best_valid_q = 1'b0;
      end
    endcase
    res.window_score = SCORE_W'(acc);
    res.best_score   = BEST_W'(best_score_q);
    res.best_start   = ADDR_W'(best_start_q);
    res.best_valid   = best_valid_q;
    return res;
  endfunction

  task automatic note_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cur_valid = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_scores.insert(expected_scores.size(), predict_score(cur_req));
        cur_valid = 1'b0;
      end
      if (!cur_valid && pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        cur_valid = 1'b1;
      end
      if (cur_valid && $urandom_range(99) >= idle_pct) begin
        start             <= 1'b1;
        in_operation      <= cur_req.op;
        in_position       <= cur_req.position;
        in_symbol         <= cur_req.symbol;
        in_a_window_start <= cur_req.a_start;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    score_result_t e;
    if (rst_n && out_valid) begin
      if (expected_scores.size() == 0) begin
        note_mismatch("result with no request pending", 0, 1);
      end else begin
        e = expected_scores.pop_front();
        if (out_window_score !== e.window_score)
          note_mismatch("window_score", longint'(e.window_score), longint'(out_window_score));
        if (out_best_score !== e.best_score)
          note_mismatch("best_score", e.best_score, out_best_score);
        if (out_best_start !== e.best_start)
          note_mismatch("best_start", e.best_start, out_best_start);
        if (out_best_valid !== e.best_valid)
          note_mismatch("best_valid", e.best_valid, out_best_valid);
        if (out_range_error !== e.range_error)
          note_mismatch("range_error", e.range_error, out_range_error);
      end
    end
  end

  function automatic int rand_symbol();
    return ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(255);
  endfunction

  function automatic int pick_start();
    int room;
    room = clamp_depth(cur_a_len) - cur_wlen;
    if (cur_wlen >= 1 && room >= 0 && $urandom_range(99) < 75) begin
      case ($urandom_range(9))
        0: return room;
        1: return (room + 1 > SEQ_DEPTH - 1) ? SEQ_DEPTH - 1 : room + 1;
        2: return 0;
        default: return $urandom_range(room);
      endcase
    end
    return $urandom_range(SEQ_DEPTH - 1);
  endfunction

  task automatic queue_req(op_t op, int pos, int sym, int a_start);
    match_req_t r;
    r.op       = op;
    r.position = ADDR_W'((op == OP_WRITE_A || op == OP_WRITE_B) ? pos : $urandom_range(1023));
    r.symbol   = SYM_W'((op == OP_WRITE_A || op == OP_WRITE_B) ? sym : $urandom_range(255));
    r.a_start  = ADDR_W'((op == OP_SCORE) ? a_start : $urandom_range(1023));
    pending_reqs.insert(pending_reqs.size(), r);
    phase_items++;
    if (op == OP_WRITE_A) begin
      plan_a[pos]     = SYM_W'(sym);
      plan_a_set[pos] = 1'b1;
    end else if (op == OP_WRITE_B) begin
      plan_b[pos]     = SYM_W'(sym);
      plan_b_set[pos] = 1'b1;
    end
  endtask

  // for an in-range window, load what it reads that is not yet written (all of A when rewrite_a), then score it
  task automatic fill_and_score(int a_start, bit rewrite_a, int mutate_pct);
    int sym;
    if (window_loaded(a_start)) begin
      for (int k = 0; k < cur_wlen; k++)
        if (!plan_b_set[cur_b_start + k])
          queue_req(OP_WRITE_B, cur_b_start + k, rand_symbol(), 0);
      for (int k = 0; k < cur_wlen; k++) begin
        if (rewrite_a || !plan_a_set[a_start + k]) begin
          sym = ($urandom_range(99) < mutate_pct) ? rand_symbol()
                                                  : int'(plan_b[cur_b_start + k]);
          queue_req(OP_WRITE_A, a_start + k, sym, 0);
        end
      end
    end
    queue_req(OP_SCORE, 0, 0, a_start);
    last_start = a_start;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || cur_valid || start || busy ||
           expected_scores.size() != 0)
      @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_reg(reg_idx_t idx, int value);
    int          width;
    logic [31:0] mask;
    logic [31:0] raw;
    case (idx)
      REG_WINDOW_LENGTH:  width = WLEN_W;
      REG_B_WINDOW_START: width = ADDR_W;
      default:            width = LEN_W;
    endcase
    mask = (32'd1 << width) - 32'd1;
    raw  = ($urandom & ~mask) | (value & mask);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= raw;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH:  cur_wlen = raw & mask;
      REG_B_WINDOW_START: cur_b_start = raw & mask;
      REG_A_LENGTH:       cur_a_len = raw & mask;
      REG_B_LENGTH:       cur_b_len = raw & mask;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (raw & mask))
      note_mismatch("register readback", raw & mask, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_registers(int wlen, int b_start, int a_len, int b_len);
    wait_drained();
    program_reg(REG_WINDOW_LENGTH, wlen);
    program_reg(REG_B_WINDOW_START, b_start);
    program_reg(REG_A_LENGTH, a_len);
    program_reg(REG_B_LENGTH, b_len);
    phase_items = 0;
  endtask

  task automatic run_phase(int wlen, int b_start, int a_len, int b_len, int budget, int idle);
    int  pick;
    int  pos;
    int  len;
    bit  on_a;
    set_registers(wlen, b_start, a_len, b_len);
    idle_pct = idle;
    fill_and_score(pick_start(), 1'b1, 0);
    while (phase_items < budget) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        fill_and_score(pick_start(), 1'b0, 20);
      end else if (pick < 55) begin
        if (cur_wlen <= 32)
          fill_and_score(pick_start(), 1'b1, ($urandom_range(2) == 0) ? 0 : 30);
        else
          fill_and_score(pick_start(), 1'b0, 20);
      end else if (pick < 62) begin
        fill_and_score($urandom_range(SEQ_DEPTH - 1), 1'b0, 20);
      end else if (pick < 85) begin
        on_a = $urandom_range(1);
        len  = clamp_depth(on_a ? cur_a_len : cur_b_len);
        pos  = $urandom_range(1) ? int'($urandom_range(SEQ_DEPTH - 1))
                                 : len - 1 + int'($urandom_range(2));
        if (pos < 0) pos = 0;
        if (pos > SEQ_DEPTH - 1) pos = SEQ_DEPTH - 1;
        queue_req(on_a ? OP_WRITE_A : OP_WRITE_B, pos, rand_symbol(), 0);
      end else if (pick < 92) begin
        queue_req(OP_CLEAR, 0, 0, 0);
      end else begin
        fill_and_score(last_start, 1'b0, 20);
      end
    end
  endtask

  initial begin : stimulus
    int w;
    int bl;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 28;

    // nothing loaded yet: writes and windows land out of range
    queue_req(OP_WRITE_A, 0, 255, 0);
    queue_req(OP_WRITE_B, SEQ_DEPTH - 1, 0, 0);
    queue_req(OP_SCORE, 0, 0, 0);
    queue_req(OP_CLEAR, 0, 0, 0);

    set_registers(4, 0, 1024, 1024);
    fill_and_score(0, 1'b1, 0);
    queue_req(OP_SCORE, 0, 0, 0);
    fill_and_score(100, 1'b1, 0);
    queue_req(OP_CLEAR, 0, 0, 0);
    fill_and_score(1020, 1'b1, 100);
    queue_req(OP_SCORE, 0, 0, 1021);
    queue_req(OP_SCORE, 0, 0, SEQ_DEPTH - 1);
    queue_req(OP_WRITE_A, SEQ_DEPTH - 1, 255, 0);
    queue_req(OP_WRITE_B, SEQ_DEPTH - 1, 255, 0);

    run_phase(8, 0, 1024, 1024, 130, 28);
    run_phase(1, 1023, 2047, 2047, 100, 28);
    run_phase(16, 500, 64, 1100, 130, 28);
    run_phase(0, 0, 1024, 1024, 50, 28);
    run_phase(256, 0, 300, 256, 600, 46);
    run_phase(257, 5, 1024, 1024, 50, 46);
    run_phase(32, 992, 1024, 1024, 120, 46);
    run_phase(511, 7, 0, 0, 50, 0);
    w  = $urandom_range(24, 1);
    bl = $urandom_range(1024, w);
    run_phase(w, $urandom_range(bl - w, 0), $urandom_range(2047), bl, 150, 0);
    run_phase(2, 0, 2, 2, 60, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("window_match_score_best_top regression: pass");
    end else begin
      $display("window_match_score_best_top regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("window_match_score_best_top regression: fail");
    $finish;
  end

endmodule

// File: window_match_score_best_top.f
+incdir+rtl
rtl/wmsb_pkg.sv
rtl/wmsb_ram.sv
rtl/window_match_score_best_top.sv
test/testbench.sv
